/* rtl/core/dmxfx_pkg.sv */
// Package of shared types, codes, constants and the breath intensity table.
package dmxfx_pkg;

  // Channel count and sine table size of this engine.
  localparam int CHANNELS     = 16;
  localparam int CHAN_W       = $clog2(CHANNELS);
  localparam int SLOT_W       = 5;
  localparam int SINE_ENTRIES = 256;
  localparam int SINE_W       = $clog2(SINE_ENTRIES);

  // Effect timing and level constants.
  localparam logic [15:0] FADE_MS     = 16'd30;
  localparam logic [7:0]  FADE_AMOUNT = 8'd15;
  localparam logic [7:0]  RAMP_AMOUNT = 8'd15;
  localparam logic [7:0]  FULL_LEVEL  = 8'd255;

  // Fixed-point constants of the sine series.
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;

  // Operation codes of an input word.
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_LEVEL  = 3'd1,
    OP_WAVE   = 3'd2,
    OP_CHASE  = 3'd3,
    OP_BREATH = 3'd4
  } op_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_FRAME_IV  = 3'd0,
    CFG_WAVE_IV   = 3'd1,
    CFG_CHASE_IV  = 3'd2,
    CFG_BREATH_IV = 3'd3,
    CFG_PHASE_INC = 3'd4,
    CFG_MIN_LEVEL = 3'd5,
    CFG_MAX_LEVEL = 3'd6,
    CFG_MASK      = 3'd7
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_WAVE,
    ST_CHASE,
    ST_BREATH,
    ST_BMUL,
    ST_BAPPLY,
    ST_EMIT
  } state_t;

  // Effect activity and fade flags.
  typedef struct packed {
    logic breath_fade;
    logic breath_on;
    logic chase_fade;
    logic chase_on;
    logic wave_fade;
    logic wave_on;
  } effect_flags_t;

  typedef logic [15:0] sine_lut_t [SINE_ENTRIES];

  // Sine of a quarter-turn fraction (0 to 16384 of 65536) in Q30, Taylor series to x^13.
  function automatic logic [63:0] quarter_sine(input logic [31:0] r);
    logic [63:0] theta;
    logic [63:0] th2;
    logic [63:0] sum;
    logic [63:0] term;
    theta = ({32'd0, r} * TWO_PI_Q30) >> 16;
    th2   = (theta * theta) >> 30;
    sum   = theta;
    term  = theta;
    for (int k = 1; k <= 6; k++) begin
      term = (term * th2) >> 30;
      unique case (k)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        default: term = term / 64'd156;
      endcase
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  // Intensity (sin+1)/2 in Q0.16 for every table index, worked out at elaboration.
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t   lut;
    logic [31:0] t;
    logic [31:0] r;
    logic [63:0] s;
    logic [63:0] v;
    for (int idx = 0; idx < SINE_ENTRIES; idx++) begin
      t = 32'(idx) << (16 - SINE_W);
      r = {18'd0, t[13:0]};
      if (t[14]) r = 32'd16384 - r;
      s = quarter_sine(r);
      if (!t[15]) v = (ONE_Q30 + s + 64'd16384) >> 15;
      else v = (ONE_Q30 - s + 64'd16384) >> 15;
      if (v > 64'd65535) v = 64'd65535;
      lut[idx] = v[15:0];
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

/* rtl/core/dmx_light_effect_engine_top.sv */
// Lighting effect engine: wave, chaser and breath effects with fades, and DMX frame output.
//
// A time tick that is due runs a short sequencer and then sends one frame of
// CHANNELS+1 words (start code 0, then each channel level), one word a cycle while the
// output is not stalled. A due tick steps through the frame, wave, chase and breath states
// (and the breath table read and multiply when breath updates) before the first word; the
// time comparisons all go through one shared 32-bit subtract-and-compare unit, one
// comparison a cycle. A tick that is not due goes back to idle after the frame check. The
// input is stalled while a tick is being worked on or its frame is still being sent.
module dmx_light_effect_engine_top
  import dmxfx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        op,
  input  logic [31:0]       now_ms,
  input  logic [3:0]        channel,
  input  logic [7:0]        level,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] slot,
  output logic [7:0]        slot_value,
  output logic              last
);

  state_t        state;
  state_t        state_next;
  effect_flags_t flags;

  logic [15:0] frame_iv;
  logic [15:0] wave_iv;
  logic [15:0] chase_iv;
  logic [15:0] breath_iv;
  logic [15:0] phase_inc;
  logic [7:0]  min_level;
  logic [7:0]  max_level;
  logic [15:0] breath_mask;

  logic [7:0]  levels [CHANNELS];
  logic [7:0]  chase_levels [CHANNELS];
  logic [31:0] now_r;
  logic [31:0] frame_last;
  logic [31:0] wave_last;
  logic [31:0] fade_last;
  logic [31:0] chase_last;
  logic [31:0] breath_last;
  logic [CHAN_W-1:0] wave_pos;
  logic [CHAN_W-1:0] chase_pos;
  logic [CHAN_W-1:0] chase_pos_next;
  logic [15:0] breath_phase;
  logic [15:0] intensity;
  logic [23:0] product;
  logic        breath_down;
  logic [SLOT_W-1:0] emit_slot;

  logic [31:0] cmp_last;
  logic [15:0] cmp_limit;
  logic [31:0] elapsed;
  logic        due;
  logic        emit_load;
  logic        any_level;
  logic        any_chase;

  // Shared unit: wrapping elapsed time against the selected interval.
  assign elapsed = now_r - cmp_last;
  assign due     = elapsed >= {16'd0, cmp_limit};

  // Any nonzero level, for ending a fade.
  always_comb begin
    any_level = 1'b0;
    any_chase = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (levels[i] != 8'd0) any_level = 1'b1;
      if (chase_levels[i] != 8'd0) any_chase = 1'b1;
    end
  end

  // Chaser position after an optional step.
  always_comb begin
    chase_pos_next = chase_pos;
    if (due) begin
      if (chase_pos == CHAN_W'(CHANNELS - 1)) chase_pos_next = '0;
      else chase_pos_next = chase_pos + 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid && op == OP_TICK) state_next = ST_FRAME;
      ST_FRAME:  state_next = due ? ST_WAVE : ST_IDLE;
      ST_WAVE:   state_next = ST_CHASE;
      ST_CHASE:  state_next = ST_BREATH;
      ST_BREATH: state_next = (flags.breath_on && due) ? ST_BMUL : ST_EMIT;
      ST_BMUL:   state_next = ST_BAPPLY;
      ST_BAPPLY: state_next = ST_EMIT;
      ST_EMIT:   if (emit_load && emit_slot == SLOT_W'(CHANNELS)) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and operand selection of the shared unit.
  always_comb begin
    in_stall  = state != ST_IDLE;
    emit_load = (state == ST_EMIT) && (!out_valid || !out_stall);
    cmp_last  = frame_last;
    cmp_limit = frame_iv;
    unique case (state)
      ST_WAVE: begin
        cmp_last  = flags.wave_on ? wave_last : fade_last;
        cmp_limit = flags.wave_on ? wave_iv : FADE_MS;
      end
      ST_CHASE: begin
        cmp_last  = flags.chase_on ? chase_last : fade_last;
        cmp_limit = flags.chase_on ? chase_iv : FADE_MS;
      end
      ST_BREATH: begin
        cmp_last  = flags.breath_on ? breath_last : fade_last;
        cmp_limit = flags.breath_on ? breath_iv : FADE_MS;
      end
      default: begin
        cmp_last  = frame_last;
        cmp_limit = frame_iv;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_iv    <= 16'd30;
      wave_iv     <= 16'd100;
      chase_iv    <= 16'd100;
      breath_iv   <= 16'd30;
      phase_inc   <= 16'd522;
      min_level   <= 8'd10;
      max_level   <= 8'd255;
      breath_mask <= 16'd0;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_IV:  frame_iv    <= cfg_data;
        CFG_WAVE_IV:   wave_iv     <= cfg_data;
        CFG_CHASE_IV:  chase_iv    <= cfg_data;
        CFG_BREATH_IV: breath_iv   <= cfg_data;
        CFG_PHASE_INC: phase_inc   <= cfg_data;
        CFG_MIN_LEVEL: min_level   <= cfg_data[7:0];
        CFG_MAX_LEVEL: max_level   <= cfg_data[7:0];
        CFG_MASK:      breath_mask <= cfg_data;
        default:       breath_mask <= breath_mask;
      endcase
    end
  end

  // Breath datapath: table read, then multiply, registered apart.
  always_ff @(posedge clk) begin
    if (state == ST_BREATH) begin
      intensity   <= SINE_LUT[breath_phase[15 -: SINE_W]];
    end
    if (state == ST_BMUL) begin
      breath_down <= max_level < min_level;
      product     <= {8'd0, intensity} *
                     {16'd0, ((max_level >= min_level) ? (max_level - min_level)
                                                       : (min_level - max_level))};
    end
  end

  // Effect state, channel levels and timers.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags        <= '0;
      frame_last   <= '0;
      wave_last    <= '0;
      fade_last    <= '0;
      chase_last   <= '0;
      breath_last  <= '0;
      wave_pos     <= '0;
      chase_pos    <= '0;
      breath_phase <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        levels[i]       <= 8'd0;
        chase_levels[i] <= 8'd0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            now_r <= now_ms;
            unique case (op)
              OP_LEVEL: levels[channel[CHAN_W-1:0]] <= level;
              OP_WAVE: begin
                if (flags.wave_on) flags.wave_fade <= 1'b1;
                flags.wave_on <= !flags.wave_on;
              end
              OP_CHASE: begin
                if (flags.chase_on) flags.chase_fade <= 1'b1;
                flags.chase_on <= !flags.chase_on;
              end
              OP_BREATH: begin
                if (flags.breath_on) flags.breath_fade <= 1'b1;
                flags.breath_on <= !flags.breath_on;
              end
              default: ;
            endcase
          end
        end
        ST_FRAME: if (due) frame_last <= now_r;
        ST_WAVE: begin
          if (flags.wave_on) begin
            flags.wave_fade <= 1'b0;
            if (due) begin
              wave_last <= now_r;
              for (int i = 0; i < CHANNELS; i++) begin
                levels[i] <= (wave_pos == CHAN_W'(i - 1) ||
                              (i == 0 && wave_pos == CHAN_W'(CHANNELS - 1)))
                             ? FULL_LEVEL : 8'd0;
              end
              wave_pos <= (wave_pos == CHAN_W'(CHANNELS - 1)) ? '0 : wave_pos + 1'b1;
            end
          end else if (flags.wave_fade && due) begin
            fade_last <= now_r;
            if (!any_level) flags.wave_fade <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
              levels[i] <= (levels[i] > FADE_AMOUNT) ? levels[i] - FADE_AMOUNT : 8'd0;
            end
          end
        end
        ST_CHASE: begin
          if (flags.chase_on) begin
            flags.chase_fade <= 1'b0;
            if (due) chase_last <= now_r;
            chase_pos <= chase_pos_next;
            for (int i = 0; i < CHANNELS; i++) begin
              if (chase_pos_next == CHAN_W'(i)) begin
                chase_levels[i] <= (chase_levels[i] > FULL_LEVEL - RAMP_AMOUNT)
                                   ? FULL_LEVEL : chase_levels[i] + RAMP_AMOUNT;
                levels[i]       <= (chase_levels[i] > FULL_LEVEL - RAMP_AMOUNT)
                                   ? FULL_LEVEL : chase_levels[i] + RAMP_AMOUNT;
              end else begin
                chase_levels[i] <= (chase_levels[i] > RAMP_AMOUNT)
                                   ? chase_levels[i] - RAMP_AMOUNT : 8'd0;
                levels[i]       <= (chase_levels[i] > RAMP_AMOUNT)
                                   ? chase_levels[i] - RAMP_AMOUNT : 8'd0;
              end
            end
          end else if (flags.chase_fade && due) begin
            fade_last <= now_r;
            if (!any_chase) flags.chase_fade <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
              if (chase_levels[i] != 8'd0) begin
                chase_levels[i] <= (chase_levels[i] > RAMP_AMOUNT)
                                   ? chase_levels[i] - RAMP_AMOUNT : 8'd0;
                levels[i]       <= (chase_levels[i] > RAMP_AMOUNT)
                                   ? chase_levels[i] - RAMP_AMOUNT : 8'd0;
              end
            end
          end
        end
        ST_BREATH: begin
          if (flags.breath_on) begin
            flags.breath_fade <= 1'b0;
            if (due) breath_last <= now_r;
          end else if (flags.breath_fade && due) begin
            fade_last <= now_r;
            if (!any_level) flags.breath_fade <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
              levels[i] <= (levels[i] > FADE_AMOUNT) ? levels[i] - FADE_AMOUNT : 8'd0;
            end
          end
        end
        ST_BAPPLY: begin
          for (int i = 0; i < CHANNELS && i < 16; i++) begin
            if (breath_mask[i]) begin
              levels[i] <= breath_down ? min_level - product[23:16]
                                       : min_level + product[23:16];
            end
          end
          breath_phase <= breath_phase + phase_inc;
        end
        default: frame_last <= frame_last;
      endcase
    end
  end

  // Output register: one frame word a cycle while the far side takes them.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      emit_slot <= '0;
    end else begin
      if (state == ST_FRAME) emit_slot <= '0;
      if (emit_load) begin
        out_valid  <= 1'b1;
        slot       <= emit_slot;
        slot_value <= (emit_slot == '0) ? 8'd0 : levels[CHAN_W'(emit_slot - 1'b1)];
        last       <= emit_slot == SLOT_W'(CHANNELS);
        emit_slot  <= emit_slot + 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The final word of a frame is the one with the highest slot.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (slot == SLOT_W'(CHANNELS))))
    else $error("last flag does not match the final slot");

  // Inside a frame the next word follows at once.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> (out_valid && slot == $past(slot) + 1'b1))
    else $error("frame words are not sent back to back");

  // The start code is always zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && slot == '0) |-> (slot_value == 8'd0))
    else $error("start code is not zero");

  // An active effect has had its fade flag cleared by the time the frame goes out.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> !(flags.wave_on && flags.wave_fade) &&
                           !(flags.chase_on && flags.chase_fade) &&
                           !(flags.breath_on && flags.breath_fade))
    else $error("active effect still marked as fading");

endmodule

/* tb/dmx_light_effect_engine_top_tb.sv */
// Self-checking testbench for the DMX light effect engine: directed table, then random phases.
`timescale 1ns / 100ps

module dmx_light_effect_engine_top_tb;
  import dmxfx_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 75;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    CK_PRED,
    CK_NONE,
    CK_ZERO
  } row_check_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] now;
    logic [3:0]  ch;
    logic [7:0]  lv;
    row_check_t  ck;
  } stim_row_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [7:0]        value;
    logic              last;
  } slot_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [15:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        op = '0;
  logic [31:0]       now_ms = '0;
  logic [3:0]        channel = '0;
  logic [7:0]        level = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SLOT_W-1:0] slot;
  logic [7:0]        slot_value;
  logic              last;

  // Predicted engine state and register copy.
  logic [15:0]   reg_copy [8];
  logic [7:0]    chan_lv [CHANNELS];
  logic [7:0]    chase_lv [CHANNELS];
  effect_flags_t fx;
  logic [31:0]   t_frame, t_wave, t_fade, t_chase, t_breath;
  logic [3:0]    wave_pos, chase_pos;
  logic [15:0]   phase_acc;

  slot_word_t  frame_words_q [$];
  stim_row_t   dir_rows [$];
  int          mismatches = 0;
  int          frames_seen = 0;
  int          words_seen = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  dmx_light_effect_engine_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .now_ms     (now_ms),
    .channel    (channel),
    .level      (level),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .slot       (slot),
    .slot_value (slot_value),
    .last       (last)
  );

  always #5 clk = ~clk;

  // Sine of a quarter turn fraction in Q30, series up to the x^13 term.
  function automatic logic [63:0] sine_q30(input logic [31:0] r);
    logic [63:0] theta, th2, sum, term;
    theta = ({32'd0, r} * 64'd6746518852) >> 16;
    th2   = (theta * theta) >> 30;
    sum   = theta;
    term  = theta;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * th2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum > 64'd1073741824) sum = 64'd1073741824;
    return sum;
  endfunction

  // Breath intensity (sin+1)/2 in Q0.16 for a phase, quantised to the table step.
  function automatic logic [15:0] breath_level_gain(input logic [15:0] ph);
    logic [31:0] t, r;
    logic [63:0] s, v;
    t = {16'd0, ph[15:8], 8'd0};
    r = {18'd0, t[13:0]};
    if (t[14]) r = 32'd16384 - r;
    s = sine_q30(r);
    if (!t[15]) v = (64'd1073741824 + s + 64'd16384) >> 15;
    else v = (64'd1073741824 - s + 64'd16384) >> 15;
    if (v > 64'd65535) v = 64'd65535;
    return v[15:0];
  endfunction

  // Fade every lit channel by one step; reports whether any was lit.
  function automatic bit fade_channels();
    bit any = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (chan_lv[i] != 0) begin
        chan_lv[i] = (chan_lv[i] > FADE_AMOUNT) ? chan_lv[i] - FADE_AMOUNT : 8'd0;
        any = 1'b1;
      end
    end
    return any;
  endfunction

  // Run the three effects for a due frame.
  task automatic run_frame_effects(input logic [31:0] now);
    logic [15:0] gain;
    logic [7:0]  mn, mx, lvl;
    logic [31:0] c;
    bit          any;
    if (fx.wave_on) begin
      fx.wave_fade = 1'b0;
      if (now - t_wave >= {16'd0, reg_copy[CFG_WAVE_IV]}) begin
        t_wave = now;
        wave_pos = wave_pos + 4'd1;
        for (int i = 0; i < CHANNELS; i++) chan_lv[i] = 8'd0;
        chan_lv[wave_pos] = FULL_LEVEL;
      end
    end else if (fx.wave_fade) begin
      if (now - t_fade >= {16'd0, FADE_MS}) begin
        t_fade = now;
        if (!fade_channels()) fx.wave_fade = 1'b0;
      end
    end

    if (fx.chase_on) begin
      fx.chase_fade = 1'b0;
      if (now - t_chase >= {16'd0, reg_copy[CFG_CHASE_IV]}) begin
        t_chase = now;
        chase_pos = chase_pos + 4'd1;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        c = {24'd0, chase_lv[i]};
        if (i == chase_pos) c = (c + RAMP_AMOUNT > FULL_LEVEL) ? FULL_LEVEL : c + RAMP_AMOUNT;
        else c = (c > RAMP_AMOUNT) ? c - RAMP_AMOUNT : 32'd0;
        chase_lv[i] = c[7:0];
        chan_lv[i]  = c[7:0];
      end
    end else if (fx.chase_fade) begin
      if (now - t_fade >= {16'd0, FADE_MS}) begin
        any = 1'b0;
        t_fade = now;
        for (int i = 0; i < CHANNELS; i++) begin
          if (chase_lv[i] != 0) begin
            chase_lv[i] = (chase_lv[i] > RAMP_AMOUNT) ? chase_lv[i] - RAMP_AMOUNT : 8'd0;
            chan_lv[i]  = chase_lv[i];
            any = 1'b1;
          end
        end
        if (!any) fx.chase_fade = 1'b0;
      end
    end

    if (fx.breath_on) begin
      fx.breath_fade = 1'b0;
      if (now - t_breath >= {16'd0, reg_copy[CFG_BREATH_IV]}) begin
        gain = breath_level_gain(phase_acc);
        mn = reg_copy[CFG_MIN_LEVEL][7:0];
        mx = reg_copy[CFG_MAX_LEVEL][7:0];
        t_breath = now;
        if (mx >= mn) lvl = mn + 8'((32'(gain) * 32'(mx - mn)) >> 16);
        else lvl = mn - 8'((32'(gain) * 32'(mn - mx)) >> 16);
        for (int i = 0; i < CHANNELS; i++)
          if (reg_copy[CFG_MASK][i]) chan_lv[i] = lvl;
        phase_acc = phase_acc + reg_copy[CFG_PHASE_INC];
      end
    end else if (fx.breath_fade) begin
      if (now - t_fade >= {16'd0, FADE_MS}) begin
        t_fade = now;
        if (!fade_channels()) fx.breath_fade = 1'b0;
      end
    end
  endtask

  // Predict the frame words caused by one accepted input word.
  task automatic predict_engine(input stim_row_t w);
    slot_word_t sw;
    bit         emit;
    emit = 1'b0;
    case (w.op)
      OP_TICK: begin
        if (w.now - t_frame >= {16'd0, reg_copy[CFG_FRAME_IV]}) begin
          t_frame = w.now;
          run_frame_effects(w.now);
          emit = 1'b1;
        end
      end
      OP_LEVEL:  chan_lv[w.ch] = w.lv;
      OP_WAVE:   if (fx.wave_on) begin fx.wave_on = 1'b0; fx.wave_fade = 1'b1; end
                 else fx.wave_on = 1'b1;
      OP_CHASE:  if (fx.chase_on) begin fx.chase_on = 1'b0; fx.chase_fade = 1'b1; end
                 else fx.chase_on = 1'b1;
      OP_BREATH: if (fx.breath_on) begin fx.breath_on = 1'b0; fx.breath_fade = 1'b1; end
                 else fx.breath_on = 1'b1;
      default: ;
    endcase
    // A typed row overrides the prediction; the state update above still stands.
    if (w.ck == CK_NONE) emit = 1'b0;
    if (w.ck == CK_ZERO) emit = 1'b1;
    if (emit) begin
      for (int k = 0; k <= CHANNELS; k++) begin
        sw.slot  = SLOT_W'(k);
        sw.value = (k == 0 || w.ck == CK_ZERO) ? 8'd0 : chan_lv[k - 1];
        sw.last  = (k == CHANNELS);
        frame_words_q.push_back(sw);
      end
    end
  endtask

  // Offer one word, at times after a random gap (never when quiet), and predict it once accepted.
  task automatic send_word(input stim_row_t w);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= w.op;
    now_ms   <= w.now;
    channel  <= w.ch;
    level    <= w.lv;
    do @(posedge clk); while (in_stall);
    predict_engine(w);
    items_sent++;
  endtask

  // Write one register and keep the register copy in step.
  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    reg_copy[idx] = (idx == CFG_MIN_LEVEL || idx == CFG_MAX_LEVEL) ? {8'd0, val[7:0]} : val;
  endtask

  task automatic drain_engine();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_words_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stall bursts, one long hold on request, none when quiet.
  initial begin : receiver
    int run_len;
    run_len = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (run_len > 0) begin
        run_len--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        run_len = $urandom_range(1, 12) - 1;
      end else begin
        out_stall <= 1'b0;
        run_len = $urandom_range(1, 20) - 1;
      end
    end
  end

  // Compare each accepted frame word with the oldest prediction.
  always @(posedge clk) begin
    slot_word_t want;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (last) frames_seen++;
      if (frame_words_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: slot %0d value %0d last %0d", slot, slot_value, last);
      end else begin
        want = frame_words_q.pop_front();
        if (slot !== want.slot || slot_value !== want.value || last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected slot %0d value %0d last %0d, got %0d %0d %0d",
                     want.slot, want.value, want.last, slot, slot_value, last);
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", frame_words_q.size());
      $display("dmx_light_effect_engine_top test failed");
      $finish;
    end
  end

  // Main sequence: reset, directed table, then random phases of settings.
  initial begin : stimulus
    stim_row_t   w;
    logic [31:0] t_now;
    int          pick;
    reg_copy = '{16'd30, 16'd100, 16'd100, 16'd30, 16'd522, 16'd10, 16'd255, 16'd0};
    for (int i = 0; i < CHANNELS; i++) begin
      chan_lv[i] = '0;
      chase_lv[i] = '0;
    end
    fx = '0;
    t_frame = '0; t_wave = '0; t_fade = '0; t_chase = '0; t_breath = '0;
    wave_pos = '0; chase_pos = '0; phase_acc = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: timing after reset, level extremes, every toggle, ignored ops.
    dir_rows.push_back('{OP_TICK,   32'd0,     4'd0,  8'd0,   CK_NONE});
    dir_rows.push_back('{OP_TICK,   32'd29,    4'd0,  8'd0,   CK_NONE});
    dir_rows.push_back('{OP_TICK,   32'd30,    4'd0,  8'd0,   CK_ZERO});
    dir_rows.push_back('{OP_LEVEL,  32'd0,     4'd0,  8'd255, CK_NONE});
    dir_rows.push_back('{OP_LEVEL,  32'd0,     4'd15, 8'd255, CK_NONE});
    dir_rows.push_back('{OP_LEVEL,  32'd0,     4'd7,  8'd1,   CK_NONE});
    dir_rows.push_back('{3'd5,      32'd0,     4'd3,  8'd9,   CK_NONE});
    dir_rows.push_back('{3'd7,      32'hFFFFFFFF, 4'd15, 8'd255, CK_NONE});
    dir_rows.push_back('{OP_TICK,   32'd60,    4'd0,  8'd0,   CK_PRED});
    dir_rows.push_back('{OP_WAVE,   32'd0,     4'd0,  8'd0,   CK_NONE});
    dir_rows.push_back('{OP_TICK,   32'd100,   4'd0,  8'd0,   CK_PRED});
    dir_rows.push_back('{OP_TICK,   32'd200,   4'd0,  8'd0,   CK_PRED});
    dir_rows.push_back('{OP_WAVE,   32'd0,     4'd0,  8'd0,   CK_NONE});
    dir_rows.push_back('{OP_TICK,   32'd240,   4'd0,  8'd0,   CK_PRED});
    dir_rows.push_back('{OP_CHASE,  32'd0,     4'd0,  8'd0,   CK_NONE});
    dir_rows.push_back('{OP_TICK,   32'd300,   4'd0,  8'd0,   CK_PRED});
    dir_rows.push_back('{OP_TICK,   32'd400,   4'd0,  8'd0,   CK_PRED});
    dir_rows.push_back('{OP_CHASE,  32'd0,     4'd0,  8'd0,   CK_NONE});
    dir_rows.push_back('{OP_TICK,   32'd430,   4'd0,  8'd0,   CK_PRED});
    dir_rows.push_back('{OP_BREATH, 32'd0,     4'd0,  8'd0,   CK_NONE});
    dir_rows.push_back('{OP_TICK,   32'd460,   4'd0,  8'd0,   CK_PRED});
    dir_rows.push_back('{OP_BREATH, 32'd0,     4'd0,  8'd0,   CK_NONE});
    dir_rows.push_back('{OP_TICK,   32'd500,   4'd0,  8'd0,   CK_PRED});
    foreach (dir_rows[i]) send_word(dir_rows[i]);
    t_now = 32'd600;

    for (int p = 0; p < PHASES; p++) begin
      drain_engine();
      // Settings: zero intervals, then maxima with inverted levels, then a long frame interval, then random ones.
      case (p)
        0: begin
          write_reg(CFG_FRAME_IV, 16'd0);  write_reg(CFG_WAVE_IV, 16'd0);
          write_reg(CFG_CHASE_IV, 16'd0);  write_reg(CFG_BREATH_IV, 16'd0);
          write_reg(CFG_PHASE_INC, 16'd0); write_reg(CFG_MIN_LEVEL, 16'd0);
          write_reg(CFG_MAX_LEVEL, 16'd255); write_reg(CFG_MASK, 16'hFFFF);
        end
        1: begin
          write_reg(CFG_FRAME_IV, 16'd1);  write_reg(CFG_WAVE_IV, 16'hFFFF);
          write_reg(CFG_CHASE_IV, 16'hFFFF); write_reg(CFG_BREATH_IV, 16'hFFFF);
          write_reg(CFG_PHASE_INC, 16'hFFFF); write_reg(CFG_MIN_LEVEL, 16'hFFFF);
          write_reg(CFG_MAX_LEVEL, 16'h0F00); write_reg(CFG_MASK, 16'h5A5A);
        end
        2: begin
          write_reg(CFG_FRAME_IV, 16'hFFFF); write_reg(CFG_PHASE_INC, 16'd4099);
          write_reg(CFG_MASK, 16'hA5A5);
        end
        default: begin
          write_reg(CFG_FRAME_IV, 16'($urandom_range(0, 40)));
          write_reg(CFG_WAVE_IV, 16'($urandom_range(0, 150)));
          write_reg(CFG_CHASE_IV, 16'($urandom_range(0, 150)));
          write_reg(CFG_BREATH_IV, 16'($urandom_range(0, 60)));
          write_reg(CFG_PHASE_INC, 16'($urandom));
          write_reg(CFG_MIN_LEVEL, 16'($urandom));
          write_reg(CFG_MAX_LEVEL, 16'($urandom));
          write_reg(CFG_MASK, 16'($urandom));
        end
      endcase
      // Some phases start just short of the time wrap or at a random time.
      if (p == 3) t_now = 32'hFFFF_FE00;
      else if (p == 5) t_now = $urandom;
      quiet = (p == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == 10) hold_req = 1'b1;
        pick = $urandom_range(0, 99);
        w.ch = 4'($urandom);
        w.lv = 8'($urandom);
        w.ck = CK_PRED;
        if (pick < 55) begin
          w.op = OP_TICK;
          if (p == 2 && $urandom_range(0, 4) == 0) t_now = t_now + $urandom_range(60000, 70000);
          else t_now = t_now + $urandom_range(0, 45);
        end else if (pick < 72) w.op = OP_LEVEL;
        else if (pick < 80) w.op = OP_WAVE;
        else if (pick < 88) w.op = OP_CHASE;
        else if (pick < 96) w.op = OP_BREATH;
        else w.op = 3'($urandom_range(5, 7));
        w.now = (w.op == OP_TICK) ? t_now : 32'($urandom);
        send_word(w);
      end
    end

    drain_engine();
    $display("Sent %0d input words over %0d register settings; checked %0d frames (%0d words).",
             items_sent, PHASES + 1, frames_seen, words_seen);
    $display("Covered all three effects with their fades, level writes and ignored ops.");
    if (mismatches == 0 && frame_words_q.size() == 0) begin
      $display("dmx_light_effect_engine_top test passed");
    end else begin
      $display("%0d mismatches, %0d words never arrived", mismatches, frame_words_q.size());
      $display("dmx_light_effect_engine_top test failed");
    end
    $finish;
  end

endmodule
